// File: rtl/sfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame receiver package
// Shared types, codes and the reflected CRC-16 byte update.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam logic [15:0] CrcPoly      = 16'h8408;
  localparam logic [7:0]  SyncReset    = 8'h02;
  localparam logic [7:0]  AddrReset    = 8'h03;
  localparam logic [7:0]  MinLen       = 8'd6;
  localparam int          CfgAddrWidth = 1;

  typedef enum logic [CfgAddrWidth-1:0] {
    REG_SYNC = 1'b0,
    REG_ADDR = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BADCRC  = 2'd2,
    KIND_LENERR  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_ADDR = 4'b0010,
    PH_LEN  = 4'b0100,
    PH_BODY = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] payload_count;
    logic [7:0] command;
    logic [7:0] data_byte;
    kind_t      kind;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/sfr_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame receiver parser
// Frame state machine, running CRC and result formation for one byte a cycle.
// ----------------------------------------------------------------------------
module sfr_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  logic [7:0]        byte_in,
  input  logic [7:0]        sync_value,
  input  logic [7:0]        device_address,
  output logic              res_valid,
  output sfr_pkg::result_t  res
);

  sfr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  declared_length_r, declared_length_nxt;
  logic [15:0] running_crc_r, running_crc_nxt;
  logic [7:0]  crc_low_byte_r, crc_low_byte_nxt;
  logic [7:0]  command_held_r, command_held_nxt;
  logic [15:0] crc_in;
  logic [15:0] crc_fed;
  logic [8:0]  pos_plus2;
  logic [8:0]  len_ext;

  assign crc_in    = (phase_r == sfr_pkg::PH_HUNT) ? 16'h0000 : running_crc_r;
  assign crc_fed   = sfr_pkg::crc_feed(crc_in, byte_in);
  assign pos_plus2 = {1'b0, byte_count_r} + 9'd2;
  assign len_ext   = {1'b0, declared_length_r};

  always_comb begin
    phase_nxt           = phase_r;
    byte_count_nxt      = byte_count_r;
    declared_length_nxt = declared_length_r;
    running_crc_nxt     = running_crc_r;
    crc_low_byte_nxt    = crc_low_byte_r;
    command_held_nxt    = command_held_r;
    res_valid           = 1'b0;
    res                 = '0;
    if (byte_valid) begin
      unique case (phase_r)
        sfr_pkg::PH_HUNT: begin
          if (byte_in == sync_value) begin
            running_crc_nxt = crc_fed;
            byte_count_nxt  = 8'd1;
            phase_nxt       = sfr_pkg::PH_ADDR;
          end
        end
        sfr_pkg::PH_ADDR: begin
          if (byte_in == device_address) begin
            running_crc_nxt = crc_fed;
            byte_count_nxt  = 8'd2;
            phase_nxt       = sfr_pkg::PH_LEN;
          end else begin
            phase_nxt = sfr_pkg::PH_HUNT;
          end
        end
        sfr_pkg::PH_LEN: begin
          declared_length_nxt = byte_in;
          if (byte_in < sfr_pkg::MinLen) begin
            phase_nxt = sfr_pkg::PH_HUNT;
            res_valid = 1'b1;
            res.kind  = sfr_pkg::KIND_LENERR;
          end else begin
            running_crc_nxt = crc_fed;
            byte_count_nxt  = 8'd3;
            phase_nxt       = sfr_pkg::PH_BODY;
          end
        end
        sfr_pkg::PH_BODY: begin
          if (byte_count_r != 8'hFF) begin
            byte_count_nxt = byte_count_r + 8'd1;
          end
          if (pos_plus2 < len_ext) begin
            running_crc_nxt = crc_fed;
            if (byte_count_r == 8'd3) begin
              command_held_nxt = byte_in;
            end else begin
              res_valid     = 1'b1;
              res.kind      = sfr_pkg::KIND_PAYLOAD;
              res.data_byte = byte_in;
            end
          end else if (pos_plus2 == len_ext) begin
            crc_low_byte_nxt = byte_in;
          end else begin
            phase_nxt         = sfr_pkg::PH_HUNT;
            res_valid         = 1'b1;
            res.kind          = ({byte_in, crc_low_byte_r} == running_crc_r) ?
                                sfr_pkg::KIND_GOOD : sfr_pkg::KIND_BADCRC;
            res.command       = command_held_r;
            res.payload_count = declared_length_r - sfr_pkg::MinLen;
          end
        end
        default: begin
          phase_nxt = sfr_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= sfr_pkg::PH_HUNT;
      byte_count_r      <= 8'd0;
      declared_length_r <= 8'd0;
      running_crc_r     <= 16'h0000;
    end else begin
      phase_r           <= phase_nxt;
      byte_count_r      <= byte_count_nxt;
      declared_length_r <= declared_length_nxt;
      running_crc_r     <= running_crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_low_byte_r <= crc_low_byte_nxt;
    command_held_r <= command_held_nxt;
  end

endmodule

// File: rtl/sfr_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame receiver output stage
// Output register with a skid register so input is taken during a stall.
// ----------------------------------------------------------------------------
module sfr_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s_valid,
  output logic              s_ready,
  input  sfr_pkg::result_t  s_data,
  output logic              m_valid,
  input  logic              m_ready,
  output sfr_pkg::result_t  m_data
);

  logic             out_valid_r;
  logic             skid_valid_r;
  sfr_pkg::result_t out_data_r;
  sfr_pkg::result_t skid_data_r;
  logic             out_free;

  assign s_ready  = !skid_valid_r;
  assign m_valid  = out_valid_r;
  assign m_data   = out_data_r;
  assign out_free = !out_valid_r || m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= s_valid;
      end
    end else if (s_valid && s_ready) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : s_data;
    end
    if (!out_free && s_valid && s_ready) begin
      skid_data_r <= s_data;
    end
  end

endmodule

// File: rtl/serial_frame_receiver_crc16_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame receiver with CRC-16 check
// Finds frames in a received byte stream, emits payload bytes and a status.
// ----------------------------------------------------------------------------
// Each input item on in_* is one received serial byte. Frames are sync,
// address, length, command, payload, CRC low and CRC high; the length counts
// the whole frame. Each payload byte comes out on out_* as a payload item, and
// the last CRC byte yields a good or CRC-mismatch status item carrying the
// command and the payload byte count. A length below six gives a length-error
// item at once. Bytes outside a frame give no item.
// The cfg_* port sets the sync value and the device address; write it only
// while no frame is in progress.
// One byte is taken every cycle while in_tready is high. A result is
// registered in the output register after its byte is accepted; the parser
// and CRC update are combinational. While the output is stalled, bytes that give
// no result keep flowing and a skid register holds one more result; once it
// is full, in_tready drops until the cycle after the output item is taken.
// Reset puts the receiver in sync hunting, empties the output, and restores
// the sync value 0x02 and the address 0x03.
// ----------------------------------------------------------------------------
module serial_frame_receiver_crc16_check (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // byte_in
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [23:0]                       out_tdata,  // payload_count [23:16], command [15:8], data_byte [7:0]
  output logic [1:0]                        out_tuser,  // kind
  input  logic                              cfg_we,
  input  logic [sfr_pkg::CfgAddrWidth-1:0]  cfg_addr,
  input  logic [7:0]                        cfg_wdata
);

  logic [7:0]       sync_value_r;
  logic [7:0]       device_address_r;
  logic             in_accept;
  logic             res_valid;
  sfr_pkg::result_t res;
  sfr_pkg::result_t out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_value_r     <= sfr_pkg::SyncReset;
      device_address_r <= sfr_pkg::AddrReset;
    end else if (cfg_we) begin
      unique case (sfr_pkg::cfg_reg_t'(cfg_addr))
        sfr_pkg::REG_SYNC: sync_value_r     <= cfg_wdata;
        sfr_pkg::REG_ADDR: device_address_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_accept = in_tvalid && in_tready;

  sfr_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_valid     (in_accept),
    .byte_in        (in_tdata),
    .sync_value     (sync_value_r),
    .device_address (device_address_r),
    .res_valid      (res_valid),
    .res            (res)
  );

  sfr_skid u_skid (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (res_valid),
    .s_ready (in_tready),
    .s_data  (res),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_data  (out_res)
  );

  assign out_tdata = {out_res.payload_count, out_res.command, out_res.data_byte};
  assign out_tuser = out_res.kind;

endmodule
